[hw/rtl/bbs_pkg.sv]
package bbs_pkg;

    // sequencer phases, also the encoding shown on the result channel
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SOUND   = 3'd1,
        PH_PAUSE   = 3'd2,
        PH_CHECK   = 3'd3,
        PH_BLOCKED = 3'd4,
        PH_UNBLOCK = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ACT_UPDATE  = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_BLOCK   = 2'd2,
        ACT_UNBLOCK = 2'd3
    } action_t;

    // configuration register indexes
    localparam logic [1:0] CFG_TONE_FREQ = 2'd0;
    localparam logic [1:0] CFG_BEEP_LEN  = 2'd1;
    localparam logic [1:0] CFG_GAP_LEN   = 2'd2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] BEEP_LEN_RESET = 16'd75;
    localparam logic [15:0] GAP_LEN_RESET  = 16'd30;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  beeps_requested;
        logic [7:0]  beeps_done;
        logic [31:0] sound_start_time;
    } seq_state_t;

    typedef struct packed {
        logic   tone_start;
        logic   tone_stop;
        phase_t phase;
    } step_result_t;

endpackage

[hw/rtl/bbs_step.sv]
module bbs_step (
    input  bbs_pkg::seq_state_t   state_cur,
    input  logic [1:0]            action,
    input  logic [7:0]            beep_count,
    input  logic [31:0]           now_ms,
    input  logic [15:0]           beep_length_ms,
    input  logic [15:0]           gap_length_ms,
    output bbs_pkg::seq_state_t   state_nxt,
    output bbs_pkg::step_result_t result
);
    import bbs_pkg::*;

    logic [31:0] elapsed;
    logic [16:0] wait_len;
    logic [7:0]  done_inc;

    // wrapping time difference against beep plus gap
    assign elapsed  = now_ms - state_cur.sound_start_time;
    assign wait_len = {1'b0, beep_length_ms} + {1'b0, gap_length_ms};
    assign done_inc = state_cur.beeps_done + 8'd1;

    always_comb begin
        state_nxt         = state_cur;
        result.tone_start = 1'b0;
        result.tone_stop  = 1'b0;
        unique case (action_t'(action))
            ACT_UPDATE: begin
                unique case (state_cur.phase)
                    PH_IDLE: begin
                        if (state_cur.beeps_requested > state_cur.beeps_done) begin
                            state_nxt.phase = PH_SOUND;
                        end
                    end
                    PH_SOUND: begin
                        state_nxt.sound_start_time = now_ms;
                        state_nxt.phase            = PH_PAUSE;
                        result.tone_start          = 1'b1;
                    end
                    PH_PAUSE: begin
                        if (elapsed >= {15'd0, wait_len}) begin
                            state_nxt.phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        if (state_cur.beeps_requested != done_inc) begin
                            state_nxt.beeps_done = done_inc;
                            state_nxt.phase      = PH_SOUND;
                        end else begin
                            state_nxt.beeps_done      = 8'd0;
                            state_nxt.beeps_requested = 8'd0;
                            state_nxt.phase           = PH_IDLE;
                            result.tone_stop          = 1'b1;
                        end
                    end
                    PH_BLOCKED: begin
                    end
                    default: begin
                        // unblocking, and codes that never arise
                        state_nxt.phase      = PH_IDLE;
                        state_nxt.beeps_done = 8'd0;
                        result.tone_stop     = 1'b1;
                    end
                endcase
            end
            ACT_REQUEST: state_nxt.beeps_requested = beep_count;
            ACT_BLOCK:   state_nxt.phase = PH_BLOCKED;
            ACT_UNBLOCK: state_nxt.phase = PH_UNBLOCK;
            default:     state_nxt = state_cur;
        endcase
        result.phase = state_nxt.phase;
    end

endmodule

[hw/rtl/beep_burst_sequencer.sv]
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | s_action, s_beep_count, s_now_ms
// m_      | out       | m_valid / m_ready  | m_tone_start, m_tone_stop, m_phase_code
// cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// two register stages: an input register, then the step logic, then the result
// register; a beat accepted on s_ shows on m_valid once it reaches the result register
// one beat per cycle sustained while m_ready is high; the sequencer state is updated in
// the cycle a beat moves from the input register to the result register
// reset (aresetn low, synchronous) empties both stages, idles the sequencer,
// clears both counts and the start time and reloads the beep and gap lengths
// m_ready low holds the result; the input register still takes one more beat

module beep_burst_sequencer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_beep_count,
    input  logic [31:0] s_now_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tone_start,
    output logic        m_tone_stop,
    output logic [2:0]  m_phase_code,

    input  logic                            cfg_wr_en,
    input  logic [bbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bbs_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import bbs_pkg::*;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_action_reg;
    logic [7:0]  in_count_reg;
    logic [31:0] in_now_reg;

    // result register
    logic         out_valid_reg;
    step_result_t out_result_reg;

    // sequencer state and configuration
    seq_state_t  state_reg;
    seq_state_t  state_next;
    step_result_t step_result;
    logic [15:0] beep_len_reg;
    logic [15:0] gap_len_reg;

    logic advance;
    logic s_accept;

    // a beat moves on when the result register is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= s_action;
            in_count_reg  <= s_beep_count;
            in_now_reg    <= s_now_ms;
        end
    end

    bbs_step u_step (
        .state_cur      (state_reg),
        .action         (in_action_reg),
        .beep_count     (in_count_reg),
        .now_ms         (in_now_reg),
        .beep_length_ms (beep_len_reg),
        .gap_length_ms  (gap_len_reg),
        .state_nxt      (state_next),
        .result         (step_result)
    );

    // sequencer state commits only when the beat leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase            <= PH_IDLE;
            state_reg.beeps_requested  <= 8'd0;
            state_reg.beeps_done       <= 8'd0;
            state_reg.sound_start_time <= 32'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // configuration; this block keeps no tone frequency register, so a write to
    // that index changes no result here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beep_len_reg <= BEEP_LEN_RESET;
            gap_len_reg  <= GAP_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BEEP_LEN: beep_len_reg <= cfg_wr_data;
                CFG_GAP_LEN:  gap_len_reg  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_tone_start = out_result_reg.tone_start;
    assign m_tone_stop  = out_result_reg.tone_stop;
    assign m_phase_code = out_result_reg.phase;

endmodule

[hw/rtl/bbs_checker.sv]
module bbs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_tone_start,
    input logic       m_tone_stop,
    input logic [2:0] m_phase_code
);
    import bbs_pkg::*;

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_tone_start)
            && $stable(m_tone_stop) && $stable(m_phase_code)))
        else $error("stalled result beat changed");

    a_start_stop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_tone_start && m_tone_stop))
        else $error("tone start and stop in one beat");

    // a tone starts only on the move into the pause phase
    a_start_pause: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tone_start) |-> (m_phase_code == PH_PAUSE))
        else $error("tone start outside pause phase");

    // a tone stop always lands the sequencer in idle
    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tone_stop) |-> (m_phase_code == PH_IDLE))
        else $error("tone stop outside idle phase");

endmodule

bind beep_burst_sequencer bbs_checker u_bbs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_tone_start (m_tone_start),
    .m_tone_stop  (m_tone_stop),
    .m_phase_code (m_phase_code)
);
